// ===== rtl/rop_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rop_pkg: shared types and constants of the radius outlier point filter
// Word formats of both channels, configuration register indexes, the control
// word of the distance unit and the coordinate helper used by it.
// ----------------------------------------------------------------------------
package rop_pkg;

    // capacity of the point store by default
    localparam int MAX_POINTS_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGHBORS = 2'd1;

    // register reset values
    localparam logic [15:0] DIST_LIMIT_RST    = 16'd1000;
    localparam logic [5:0]  MIN_NEIGHBORS_RST = 6'd2;

    // multiplier operand select codes
    localparam logic [1:0] MUL_LIM = 2'd0;
    localparam logic [1:0] MUL_X   = 2'd1;
    localparam logic [1:0] MUL_Y   = 2'd2;
    localparam logic [1:0] MUL_Z   = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] z_mm;
        logic               has_point;
        logic               frame_end;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] out_x_mm;
        logic signed [15:0] out_y_mm;
        logic signed [15:0] out_z_mm;
        logic               out_valid_point;
        logic               out_last;
        logic [6:0]         kept_total;
        logic               overflowed;
    } out_word_t;

    // control word from the sequencer to the distance unit
    typedef struct packed {
        logic       diff_en;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       lim_load;
    } rop_ctrl_t;

    // magnitude of the difference of two coordinates, always fits 16 bits
    function automatic logic [15:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [16:0] m;
        d = 17'(a) - 17'(b);
        m = d[16] ? -d : d;
        return m[15:0];
    endfunction

endpackage

// ===== rtl/rop_dist_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rop_dist_unit: shared squared-distance unit
// One 16x16 multiplier squares the limit once per frame and the three axis
// differences of each pair in turn; an accumulator sums them and the pair
// is flagged near when the sum does not exceed the squared limit.
// ----------------------------------------------------------------------------
module rop_dist_unit (
    input  logic              clk,
    input  rop_pkg::rop_ctrl_t ctrl,
    input  rop_pkg::point_t   pa,
    input  rop_pkg::point_t   pb,
    input  logic [15:0]       dist_limit,
    output logic              near
);
    import rop_pkg::*;

    logic [15:0] dx_reg;
    logic [15:0] dy_reg;
    logic [15:0] dz_reg;
    logic [31:0] prod_reg;
    logic [33:0] acc_reg;
    logic [31:0] lim_reg;
    logic [15:0] mul_op;
    logic [33:0] sum;

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_LIM: mul_op = dist_limit;
            MUL_X:   mul_op = dx_reg;
            MUL_Y:   mul_op = dy_reg;
            MUL_Z:   mul_op = dz_reg;
            default: mul_op = dist_limit;
        endcase
    end

    // axis differences, square, accumulate
    always_ff @(posedge clk)
    begin
        if (ctrl.diff_en)
        begin
            dx_reg <= abs_diff(pa.x, pb.x);
            dy_reg <= abs_diff(pa.y, pb.y);
            dz_reg <= abs_diff(pa.z, pb.z);
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= 32'(mul_op) * 32'(mul_op);
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= 34'(prod_reg);
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + 34'(prod_reg);
        end
        if (ctrl.lim_load)
        begin
            lim_reg <= prod_reg;
        end
    end

    // final add of the z term and compare against the squared limit
    assign sum  = acc_reg + 34'(prod_reg);
    assign near = (sum <= 34'(lim_reg));

endmodule

// ===== rtl/radius_outlier_point_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_outlier_point_filter_core: radius outlier filter for 3D point frames
// Collects one frame of points, counts close neighbours of every point with a
// shared squared-distance unit and emits the points that have enough of them.
// ----------------------------------------------------------------------------
// Points are taken one word per cycle while busy is low; a word with
// frame_end set starts the filtering pass and busy stays high through it,
// falling in the cycle that shows the last result word of the frame. The
// pass is paced by the single 16x16 multiplier that squares the three axis
// differences of every ordered pair of stored points in turn, followed by an
// emit scan that steps over the rejected points and shows each kept point
// in store order, up to the last kept one. Every result word is shown for
// exactly one cycle with result_strobe high and must be taken then; there is
// no back pressure. A frame that keeps nothing gives a single word with
// out_valid_point low. Points beyond MAX_POINTS are dropped and reported in
// overflowed. The configuration port is always ready and must only be
// written while idle.
// ----------------------------------------------------------------------------
module radius_outlier_point_filter_core #(
    parameter int MAX_POINTS = rop_pkg::MAX_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  rop_pkg::in_word_t              item,
    output rop_pkg::out_word_t             result,
    output logic                           result_strobe,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rop_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rop_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int TOT_W = $clog2(MAX_POINTS + 1);
    localparam int CNT_W = $clog2(MAX_POINTS);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LIM  = 4'd1;
    localparam logic [3:0] S_LIMW = 4'd2;
    localparam logic [3:0] S_RDI  = 4'd3;
    localparam logic [3:0] S_LDI  = 4'd4;
    localparam logic [3:0] S_RDJ  = 4'd5;
    localparam logic [3:0] S_DIFF = 4'd6;
    localparam logic [3:0] S_M0   = 4'd7;
    localparam logic [3:0] S_M1   = 4'd8;
    localparam logic [3:0] S_M2   = 4'd9;
    localparam logic [3:0] S_ACC  = 4'd10;
    localparam logic [3:0] S_DEC  = 4'd11;
    localparam logic [3:0] S_SEL  = 4'd12;
    localparam logic [3:0] S_RDE  = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    logic [3:0]            state_reg, state_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic                  ovf_reg, ovf_next;
    logic [TOT_W-1:0]      i_reg, i_next;
    logic [TOT_W-1:0]      j_reg, j_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TOT_W-1:0]      kept_reg, kept_next;
    logic [TOT_W-1:0]      sent_reg, sent_next;
    logic [MAX_POINTS-1:0] keep_reg, keep_next;
    logic [15:0]           dist_limit_reg, dist_limit_next;
    logic [5:0]            min_nb_reg, min_nb_next;
    logic                  strobe_reg, strobe_next;
    out_word_t             result_reg, result_next;
    point_t                pi_reg, pi_next;

    // point store
    point_t                store_mem [MAX_POINTS];
    point_t                rdata_reg;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;

    rop_ctrl_t             ctrl;
    logic                  near;
    logic                  accept;

    assign accept        = start && !busy;
    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // store write on load, registered read for the sequencer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= point_t'{item.x_mm, item.y_mm, item.z_mm};
        end
        rdata_reg <= store_mem[rd_addr];
    end

    rop_dist_unit u_dist (
        .clk        (clk),
        .ctrl       (ctrl),
        .pa         (pi_reg),
        .pb         (rdata_reg),
        .dist_limit (dist_limit_reg),
        .near       (near)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        kept_next       = kept_reg;
        sent_next       = sent_reg;
        keep_next       = keep_reg;
        dist_limit_next = dist_limit_reg;
        min_nb_next     = min_nb_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        pi_next         = pi_reg;
        wr_en           = 1'b0;
        wr_addr         = total_reg[IDX_W-1:0];
        rd_addr         = i_reg[IDX_W-1:0];
        ctrl            = '0;
        ctrl.mul_sel    = MUL_LIM;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DIST_LIMIT:    dist_limit_next = cfg_data;
                CFG_MIN_NEIGHBORS: min_nb_next     = cfg_data[5:0];
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.has_point)
                    begin
                        if (total_reg < TOT_W'(MAX_POINTS))
                        begin
                            wr_en      = 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (item.frame_end)
                    begin
                        state_next = S_LIM;
                    end
                end
            end
            S_LIM:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_LIM;
                state_next   = S_LIMW;
            end
            S_LIMW:
            begin
                ctrl.lim_load = 1'b1;
                i_next        = '0;
                state_next    = (total_reg == '0) ? S_SEL : S_RDI;
            end
            S_RDI:
            begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = S_LDI;
            end
            S_LDI:
            begin
                pi_next    = rdata_reg;
                j_next     = '0;
                cnt_next   = '0;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                rd_addr    = j_reg[IDX_W-1:0];
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                ctrl.diff_en = 1'b1;
                state_next   = S_M0;
            end
            S_M0:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_X;
                state_next   = S_M1;
            end
            S_M1:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = MUL_Y;
                ctrl.acc_load = 1'b1;
                state_next    = S_M2;
            end
            S_M2:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_Z;
                ctrl.acc_add = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                // a point is not its own neighbour
                if (near && (j_reg != i_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
                if (TOT_W'(j_reg + 1'b1) == total_reg)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    state_next = S_RDJ;
                end
            end
            S_DEC:
            begin
                if (7'(cnt_reg) >= 7'(min_nb_reg))
                begin
                    keep_next[i_reg[IDX_W-1:0]] = 1'b1;
                    kept_next                   = kept_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (TOT_W'(i_reg + 1'b1) == total_reg)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_RDI;
                end
            end
            S_SEL:
            begin
                i_next    = '0;
                sent_next = '0;
                if (kept_reg == '0)
                begin
                    // nothing kept: one empty word closes the frame
                    strobe_next                 = 1'b1;
                    result_next                 = '0;
                    result_next.out_last        = 1'b1;
                    result_next.overflowed      = ovf_reg;
                    total_next                  = '0;
                    ovf_next                    = 1'b0;
                    keep_next                   = '0;
                    state_next                  = S_IDLE;
                end
                else
                begin
                    state_next = S_RDE;
                end
            end
            S_RDE:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (keep_reg[i_reg[IDX_W-1:0]])
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                strobe_next                 = 1'b1;
                result_next.out_x_mm        = rdata_reg.x;
                result_next.out_y_mm        = rdata_reg.y;
                result_next.out_z_mm        = rdata_reg.z;
                result_next.out_valid_point = 1'b1;
                result_next.out_last        = (TOT_W'(sent_reg + 1'b1) == kept_reg);
                result_next.kept_total      = 7'(kept_reg);
                result_next.overflowed      = ovf_reg;
                sent_next                   = sent_reg + 1'b1;
                i_next                      = i_reg + 1'b1;
                if (TOT_W'(sent_reg + 1'b1) == kept_reg)
                begin
                    total_next = '0;
                    ovf_next   = 1'b0;
                    kept_next  = '0;
                    keep_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RDE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            cnt_reg        <= '0;
            kept_reg       <= '0;
            sent_reg       <= '0;
            keep_reg       <= '0;
            dist_limit_reg <= DIST_LIMIT_RST;
            min_nb_reg     <= MIN_NEIGHBORS_RST;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            cnt_reg        <= cnt_next;
            kept_reg       <= kept_next;
            sent_reg       <= sent_next;
            keep_reg       <= keep_next;
            dist_limit_reg <= dist_limit_next;
            min_nb_reg     <= min_nb_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pi_reg     <= pi_next;
    end

endmodule

// ===== rtl/rop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rop_checker: port-level checks of the radius outlier point filter
// Watches the top level ports for frame closing and result word consistency;
// bound to every instance of the top level.
// ----------------------------------------------------------------------------
module rop_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input rop_pkg::in_word_t              item,
    input rop_pkg::out_word_t             result,
    input logic                           result_strobe
);
    import rop_pkg::*;

    // a closing word makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.frame_end |=> busy)
        else $error("frame end word did not start filtering");

    // only the last word of a frame may appear while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.out_last |-> busy)
        else $error("non-final result while idle");

    // the empty word closes the frame and reports nothing kept
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.out_valid_point |->
        result.out_last && (result.kept_total == 7'd0))
        else $error("malformed empty result");

    // a kept point implies a non-zero kept count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.out_valid_point |-> (result.kept_total != 7'd0))
        else $error("kept point with zero total");

endmodule

bind radius_outlier_point_filter_core rop_checker u_rop_checker (.*);
